FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL files of the clique search block.
// Each macro expands to a labeled concurrent assertion, or to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

FILE: hdl/mcs_pkg.sv
// Package for the clique search block: kind codes, set type and status struct.
// Used by the input interface, the search engine and the top level.
`default_nettype none
package mcs_pkg;
  localparam int SET_W = 128;
  typedef logic [SET_W-1:0] vset_t;
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_CLEAR  = 2'd0;
  localparam kind_t KIND_EDGE   = 2'd1;
  localparam kind_t KIND_RUN    = 2'd2;
  localparam kind_t KIND_UNUSED = 2'd3;

  // Status from the search engine to the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } eng_stat_t;
endpackage
`default_nettype wire

FILE: hdl/mcs_in_if.sv
// Input channel interface: kind and the two endpoints of an edge word.
// Depends on mcs_pkg.
`default_nettype none
interface mcs_in_if;
  logic          valid;
  logic          ready;
  mcs_pkg::kind_t kind;
  logic [6:0]    vertex_a;
  logic [6:0]    vertex_b;
  modport source (output valid, kind, vertex_a, vertex_b, input ready);
  modport sink (input valid, kind, vertex_a, vertex_b, output ready);
endinterface
`default_nettype wire

FILE: hdl/mcs_out_if.sv
// Result channel interface: the largest clique size.
// Depends on nothing.
`default_nettype none
interface mcs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] max_clique_size;
  modport source (output valid, max_clique_size, input ready);
  modport sink (input valid, max_clique_size, output ready);
endinterface
`default_nettype wire

FILE: hdl/max_clique_search.sv
// Top level of the clique search block: handshake, config register, result register.
// Depends on mcs_pkg, mcs_in_if, mcs_out_if, mcs_engine and assert_macros.svh.
//
// Usage: words arrive on the in_ channel with kind 0 (clear graph), 1 (add edge
// vertex_a-vertex_b) or 2 (run). Kind 3 is accepted and ignored. A clear keeps the
// block busy while it sweeps the adjacency memory one row a cycle; an edge keeps
// it busy through S_EA, S_EB and S_EB2 (two row reads and two row writes on the
// adjacency memory's separate read and write ports).
// A run does a depth-first search with a stack in memory. Opening a frame passes
// S_OPEN and S_OPW and, when it is pushed, S_PIV, S_CHILD and S_DONE; a branch
// step passes S_BR and S_ROW and a pop S_POP, S_TOP and S_TOPW, so the run time
// is data-dependent, exponential in the worst case. The result is valid the
// cycle after the search finds its stack empty.
// in_ready is low while a word is in progress and while a result waits.
// A run gives one word on out_ with max_clique_size; it holds until out_ready.
// cfg_we writes vertex_count (reset 128); the user must write it only while idle,
// which the block does not enforce. Reset clears the state machine and the result
// valid flag, then sweeps every adjacency memory row clear with in_ready low.
`default_nettype none
`include "assert_macros.svh"
module max_clique_search #(
  parameter int MAX_VERTICES = 128
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mcs_in_if.sink     in_ch,
  mcs_out_if.source  out_ch,
  input  wire logic  cfg_we,
  input  wire logic [7:0] cfg_wdata
);
  logic [7:0] vcount_r;
  logic       ovalid_r;
  logic [7:0] osize_r;
  logic       run_r;
  mcs_pkg::eng_stat_t stat;
  logic [7:0] best;
  logic start;

  assign in_ch.ready = !stat.busy && !ovalid_r;
  assign start = in_ch.valid && in_ch.ready;

  mcs_engine #(.MAX_VERTICES(MAX_VERTICES)) u_eng (
    .clk(clk), .rst_n(rst_n), .start(start), .kind(in_ch.kind),
    .va(in_ch.vertex_a), .vb(in_ch.vertex_b), .vcount(vcount_r),
    .stat(stat), .best(best)
  );

  // Config register and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= 8'd128;
      ovalid_r <= 1'b0;
      run_r <= 1'b0;
    end else begin
      if (cfg_we) vcount_r <= cfg_wdata;
      if (start) run_r <= (in_ch.kind == mcs_pkg::KIND_RUN);
      if (stat.done && run_r) begin
        ovalid_r <= 1'b1;
        run_r <= 1'b0;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
    if (stat.done) osize_r <= best;
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.max_clique_size = osize_r;

  `ASSERT_CLK(a_no_start_out, ovalid_r |-> !in_ch.ready, "input taken while result waits")
  `ASSERT_CLK(a_out_hold, (ovalid_r && !out_ch.ready) |=> ovalid_r, "result dropped")
  `ASSERT_NEVER(a_range, ovalid_r && osize_r > 8'(MAX_VERTICES), "result out of range")
endmodule
`default_nettype wire

FILE: hdl/mcs_engine.sv
// Search engine: adjacency memory, frame stack memories and the sequencer.
// Depends on mcs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module mcs_engine #(
  parameter int MAX_VERTICES = 128
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire mcs_pkg::kind_t    kind,
  input  wire logic [6:0]        va,
  input  wire logic [6:0]        vb,
  input  wire logic [7:0]        vcount,
  output mcs_pkg::eng_stat_t     stat,
  output logic [7:0]             best
);
  localparam int FRAMES = MAX_VERTICES + 1;
  localparam int DW = $clog2(FRAMES + 1);
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int FW = $clog2(FRAMES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_EA    = 4'd2;
  localparam logic [3:0] S_EB    = 4'd3;
  localparam logic [3:0] S_EB2   = 4'd4;
  localparam logic [3:0] S_OPEN  = 4'd5;
  localparam logic [3:0] S_POP   = 4'd6;
  localparam logic [3:0] S_PIV   = 4'd7;
  localparam logic [3:0] S_TOP   = 4'd8;
  localparam logic [3:0] S_TOPW  = 4'd9;
  localparam logic [3:0] S_BR    = 4'd10;
  localparam logic [3:0] S_ROW   = 4'd11;
  localparam logic [3:0] S_CHILD = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;
  localparam logic [3:0] S_OPW   = 4'd14;

  // Memories: adjacency rows and the four frame stacks.
  mcs_pkg::vset_t adj_mem [MAX_VERTICES];
  mcs_pkg::vset_t cand_mem [FRAMES];
  mcs_pkg::vset_t brs_mem [FRAMES];
  logic [7:0]     bnd_mem [FRAMES];
  logic [6:0]     piv_mem [FRAMES];

  logic [3:0]      state_r, state_nxt;
  logic [DW-1:0]   depth_r, depth_nxt;
  logic [7:0]      best_r, best_nxt;
  logic [AW-1:0]   cnt_r, cnt_nxt;
  mcs_pkg::vset_t  cand_r, cand_nxt;
  mcs_pkg::vset_t  brs_r, brs_nxt;
  logic [7:0]      size_r, size_nxt;
  logic [7:0]      bnd_r, bnd_nxt;
  logic [7:0]      pc_r, pc_nxt;
  logic [6:0]      piv_r, piv_nxt;
  logic [6:0]      cv_r, cv_nxt;
  logic [6:0]      ea_r, eb_r, ea_nxt, eb_nxt;

  logic [AW-1:0]   adj_raddr;
  mcs_pkg::vset_t  adj_q;
  logic            adj_we;
  logic [AW-1:0]   adj_waddr;
  mcs_pkg::vset_t  adj_wd;
  logic [FW-1:0]   stk_raddr;
  logic [FW-1:0]   stk_waddr;
  logic            stk_we;
  mcs_pkg::vset_t  cand_q, brs_q;
  logic [7:0]      bnd_q;
  logic [6:0]      piv_q;

  // Lowest set bit of a set, as a priority encoder over all members.
  function automatic logic [6:0] low_idx(input mcs_pkg::vset_t s);
    logic [6:0] r;
    r = '0;
    for (int i = mcs_pkg::SET_W - 1; i >= 0; i--) begin
      if (s[i]) r = 7'(i);
    end
    return r;
  endfunction

  function automatic logic [7:0] popc(input mcs_pkg::vset_t s);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < mcs_pkg::SET_W; i++) r = r + 8'(s[i]);
    return r;
  endfunction

  mcs_pkg::vset_t all_set;
  logic [7:0] ncl;
  always_comb begin
    ncl = (vcount > 8'(MAX_VERTICES)) ? 8'(MAX_VERTICES) : vcount;
    for (int i = 0; i < mcs_pkg::SET_W; i++) all_set[i] = (8'(i) < ncl);
  end

  // Memory ports.
  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_waddr] <= adj_wd;
    adj_q <= adj_mem[adj_raddr];
    if (stk_we) begin
      cand_mem[stk_waddr] <= cand_r;
      brs_mem[stk_waddr]  <= brs_r;
      bnd_mem[stk_waddr]  <= bnd_r;
      piv_mem[stk_waddr]  <= piv_r;
    end
    cand_q <= cand_mem[stk_raddr];
    brs_q  <= brs_mem[stk_raddr];
    bnd_q  <= bnd_mem[stk_raddr];
    piv_q  <= piv_mem[stk_raddr];
  end

  logic [6:0] low_b;
  logic [6:0] csel;
  logic [7:0] cnt_bits;
  logic       ok_a, ok_b;
  assign low_b = low_idx(brs_r);
  assign csel = (8'(low_b) >= 8'(MAX_VERTICES)) ? 7'd0 : low_b;
  assign cnt_bits = popc(cand_r);
  assign ok_a = (8'(ea_r) < 8'(MAX_VERTICES));
  assign ok_b = (8'(eb_r) < 8'(MAX_VERTICES));

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    depth_nxt = depth_r;
    best_nxt  = best_r;
    cnt_nxt   = cnt_r;
    cand_nxt  = cand_r;
    brs_nxt   = brs_r;
    size_nxt  = size_r;
    bnd_nxt   = bnd_r;
    pc_nxt    = pc_r;
    piv_nxt   = piv_r;
    cv_nxt    = cv_r;
    ea_nxt    = ea_r;
    eb_nxt    = eb_r;
    adj_raddr = piv_r[AW-1:0];
    adj_we    = 1'b0;
    adj_waddr = cnt_r;
    adj_wd    = '0;
    stk_we    = 1'b0;
    stk_waddr = size_r[FW-1:0];
    stk_raddr = FW'(depth_r - DW'(1));
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ea_nxt = va;
          eb_nxt = vb;
          case (kind)
            mcs_pkg::KIND_CLEAR: begin
              cnt_nxt = '0;
              state_nxt = S_CLR;
            end
            mcs_pkg::KIND_EDGE: state_nxt = S_EA;
            mcs_pkg::KIND_RUN: begin
              best_nxt = '0;
              depth_nxt = '0;
              cand_nxt = all_set;
              size_nxt = '0;
              state_nxt = S_OPEN;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        adj_we = 1'b1;
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == AW'(MAX_VERTICES - 1)) state_nxt = S_IDLE;
      end
      S_EA: begin
        if (ok_a && ok_b && ea_r != eb_r) begin
          adj_raddr = ea_r[AW-1:0];
          state_nxt = S_EB;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EB: begin
        adj_raddr = eb_r[AW-1:0];
        adj_we = 1'b1;
        adj_waddr = ea_r[AW-1:0];
        adj_wd = adj_q | (mcs_pkg::vset_t'(1) << eb_r);
        state_nxt = S_EB2;
      end
      S_EB2: begin
        adj_we = 1'b1;
        adj_waddr = eb_r[AW-1:0];
        adj_wd = adj_q | (mcs_pkg::vset_t'(1) << ea_r);
        state_nxt = S_IDLE;
      end
      S_OPEN: begin
        // Frame open, step one: update best, count candidates.
        if (size_r > best_r) best_nxt = size_r;
        pc_nxt = cnt_bits;
        state_nxt = S_OPW;
      end
      S_OPW: begin
        bnd_nxt = size_r + pc_r;
        piv_nxt = low_idx(cand_r);
        if (size_r + pc_r <= best_r || 9'(size_r) >= 9'(FRAMES)) begin
          state_nxt = S_POP;
        end else begin
          if (8'(low_idx(cand_r)) >= 8'(MAX_VERTICES)) piv_nxt = '0;
          state_nxt = S_PIV;
        end
      end
      S_PIV: begin
        adj_raddr = piv_r[AW-1:0];
        state_nxt = S_CHILD;
      end
      S_CHILD: begin
        // Branch set of the new frame; the frame is pushed in S_DONE.
        brs_nxt = cand_r & ~adj_q;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        stk_we = 1'b1;
        depth_nxt = DW'(size_r) + DW'(1);
        state_nxt = S_POP;
      end
      S_POP: begin
        if (depth_r == '0) state_nxt = S_IDLE;
        else state_nxt = S_TOP;
      end
      S_TOP: state_nxt = S_TOPW;
      S_TOPW: begin
        cand_nxt = cand_q;
        brs_nxt = brs_q;
        bnd_nxt = bnd_q;
        piv_nxt = piv_q;
        size_nxt = 8'(depth_r - DW'(1));
        if (brs_q != '0 && bnd_q > best_r) begin
          state_nxt = S_BR;
        end else begin
          depth_nxt = depth_r - DW'(1);
          state_nxt = S_POP;
        end
      end
      S_BR: begin
        cv_nxt = csel;
        cand_nxt = cand_r ^ (mcs_pkg::vset_t'(1) << csel);
        brs_nxt = brs_r ^ (mcs_pkg::vset_t'(1) << csel);
        bnd_nxt = bnd_r - 8'd1;
        adj_raddr = csel[AW-1:0];
        state_nxt = S_ROW;
      end
      default: begin
        // S_ROW: write back the updated frame, then maybe open a child.
        stk_we = 1'b1;
        if (cv_r == piv_r || (brs_r & adj_q) != '0) begin
          cand_nxt = cand_r & adj_q;
          size_nxt = size_r + 8'd1;
          state_nxt = S_OPEN;
        end else begin
          state_nxt = S_POP;
        end
      end
    endcase
  end

  // Reset starts a clearing sweep of the adjacency rows.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      depth_r <= '0;
      best_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
      best_r  <= best_nxt;
      cnt_r   <= cnt_nxt;
    end
    cand_r <= cand_nxt;
    brs_r  <= brs_nxt;
    size_r <= size_nxt;
    bnd_r  <= bnd_nxt;
    pc_r   <= pc_nxt;
    piv_r  <= piv_nxt;
    cv_r   <= cv_nxt;
    ea_r   <= ea_nxt;
    eb_r   <= eb_nxt;
  end

  assign stat.busy = (state_r != S_IDLE);
  assign stat.done = (state_r == S_POP) && (depth_r == '0);
  assign best = best_r;

  `ASSERT_CLK(a_depth_bound, depth_r <= DW'(FRAMES), "stack depth overflow")
  `ASSERT_CLK(a_best_bound, best_r <= 8'(MAX_VERTICES), "best size out of range")
  `ASSERT_CLK(a_done_busy, stat.done |-> stat.busy, "done while idle")
endmodule
`default_nettype wire
